[rtl/hashed_item_dispatch_batcher_macros.svh]
// ============================================================================
// Assertion macros for the key dispatcher.
// Shared helper macros for concurrent checks.
// ============================================================================
`ifndef HASHED_ITEM_DISPATCH_BATCHER_MACROS_SVH
`define HASHED_ITEM_DISPATCH_BATCHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HIDB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HIDB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/hidb_pkg.sv]
// ============================================================================
// Dispatcher package
// Constants, hash function and shared types for the key dispatcher.
// ============================================================================
`timescale 1ns / 1ps
package hidb_pkg;
   localparam int MaxRanksDefault = 32;
   localparam int MaxUnitsDefault = 64;
   localparam int CountBitsDefault = 16;
   localparam logic [63:0] Seed0 = 64'hAAAAAAAA55555555 * 64'hB5B5B5B54B4B4B4B;
   localparam logic [63:0] Seed1 = 64'h33333333CCCCCCCC * 64'hAA55AA5555335533;

   typedef enum logic [1:0] {
      CSR_RANK_COUNT = 2'd0,
      CSR_UNITS_PER_RANK = 2'd1,
      CSR_BATCH_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLR_IDLE = 2'd0,
      CLR_SWEEP = 2'd1
   } clear_state_type;

   // First mixing round; kprod is the low 64 bits of key times the seed shifted right by 3.
   function automatic logic [63:0] mix_front(input logic [63:0] key, input logic [63:0] kprod,
                                             input logic [63:0] s);
      logic [63:0] h;
      h = s;
      h = h ^ ((h << 7) ^ kprod ^ (~((h << 11) + (key ^ (h >> 5)))));
      h = (~h) + (h << 21);
      h = h ^ (h >> 24);
      return h;
   endfunction

   function automatic logic [63:0] mix_mid(input logic [63:0] hi);
      logic [63:0] h;
      h = hi * 64'd265;
      h = h ^ (h >> 14);
      return h;
   endfunction

   function automatic logic [63:0] mix_back(input logic [63:0] hi);
      logic [63:0] h;
      h = hi * 64'd21;
      h = h ^ (h >> 28);
      h = h + (h << 31);
      return h;
   endfunction
endpackage

[rtl/hidb_hash.sv]
// ============================================================================
// Dispatcher hash pipeline
// Four-stage mix of the key under one seed, then fastrange on the low word.
// ============================================================================
`timescale 1ns / 1ps
module hidb_hash
   import hidb_pkg::*;
#(
   parameter logic [63:0] SEED = 64'd0,
   parameter int RANGE_BITS = 7
) (
   input  logic clock,
   input  logic advance,
   input  logic [63:0] key_value,
   input  logic [RANGE_BITS-1:0] range,
   output logic [RANGE_BITS-1:0] picked
);
   localparam logic [63:0] SeedShift = SEED >> 3;

   logic [63:0] mul_lo_ff, mul_lo_in, xs_ff;
   logic [31:0] mul_hi_ff, mul_hi_in;
   logic [63:0] s1_ff, s2_ff, s3_ff;
   logic [31+RANGE_BITS:0] prod;

   // The low 64 bits of key times the shifted seed come from three 32-bit partial products.
   assign mul_lo_in = 64'(key_value[31:0]) * 64'(SeedShift[31:0]);
   assign mul_hi_in = key_value[31:0] * SeedShift[63:32] + key_value[63:32] * SeedShift[31:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_lo_ff <= mul_lo_in;
         mul_hi_ff <= mul_hi_in;
         xs_ff <= key_value;
         s1_ff <= mix_front(xs_ff, mul_lo_ff + {mul_hi_ff, 32'd0}, SEED);
         s2_ff <= mix_mid(s1_ff);
         s3_ff <= mix_back(s2_ff);
      end
   end

   assign prod = s3_ff[31:0] * range;
   assign picked = prod[31+RANGE_BITS:32];
endmodule

[rtl/hidb_counter_mem.sv]
// ============================================================================
// Dispatcher fill counter memory
// Synchronous counter store with one read and one write port.
// ============================================================================
`timescale 1ns / 1ps
module hidb_counter_mem
   import hidb_pkg::*;
#(
   parameter int ADDR_BITS = 11,
   parameter int COUNT_BITS = 16
) (
   input  logic clock,
   input  logic rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [COUNT_BITS-1:0] rd_data,
   input  logic wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [COUNT_BITS-1:0] wr_data
);
   logic [COUNT_BITS-1:0] mem_ff [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

[rtl/hashed_item_dispatch_batcher.sv]
// Keys are taken one at a time: a new req transfer waits for the previous key's counter update.
// The next key may be taken while a response waits; it then stalls at the counter update.
// A key that launches its rank starts a clearing sweep of that rank's counters, and an
// end-of-batch key a sweep of all counters; no key is taken during a sweep.
// After reset a sweep clears all the counters. Reset is synchronous, active
// high, and restores the register defaults.
// ============================================================================
// Hashed key dispatcher
// Hashes keys to rank and unit, counts fills per unit and flags batch launches.
// ============================================================================
`timescale 1ns / 1ps
module hashed_item_dispatch_batcher
   import hidb_pkg::*;
#(
   parameter int MAX_RANKS = MaxRanksDefault,
   parameter int MAX_UNITS = MaxUnitsDefault,
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [63:0] req_key_value,
   input  logic req_end_of_batch,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [4:0] rsp_rank_index,
   output logic [5:0] rsp_unit_index,
   output logic [15:0] rsp_slot_index,
   output logic rsp_rank_launch,
   output logic rsp_flush_all,
   output logic [31:0] rsp_flushed_ranks,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data
);
   localparam int RB = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int UB = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int AB = RB + UB;
   localparam int SWEEP_ALL = 2 ** AB;
   localparam int SWEEP_RANK = 2 ** UB;
   localparam int PIPE = 4;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [5:0] rank_count_ff;
   logic [6:0] units_ff;
   logic [15:0] limit_ff;
   logic [6:0] nr, nu;

   // Items are processed one at a time: hash pipeline, then memory RMW.
   logic busy_ff, busy_in;
   logic [PIPE:0] stage_ff;
   logic end_ff [PIPE+1];
   logic fire;
   logic [6:0] rank_w, unit_w;
   logic [RB-1:0] rank_s;
   logic [UB-1:0] unit_s;
   logic [RB-1:0] rank_hold_ff;
   logic [UB-1:0] unit_hold_ff;
   logic [COUNT_BITS-1:0] rd_data, count;
   logic mem_rd, mem_wr;
   logic [AB-1:0] rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [MAX_RANKS-1:0] nonempty_ff, nonempty_in;
   clear_state_type cstate_ff, cstate_in;
   logic [AB:0] clr_ptr_ff, clr_ptr_in, clr_end_ff, clr_end_in;
   logic launch;
   logic [31:0] flushed;
   logic rsp_valid_ff;

   assign nr = ({1'b0, rank_count_ff} > 7'(MAX_RANKS)) ? 7'(MAX_RANKS) : {1'b0, rank_count_ff};
   assign nu = (units_ff > 7'(MAX_UNITS)) ? 7'(MAX_UNITS) : units_ff;

   assign req_ready = !busy_ff && (cstate_ff == CLR_IDLE) && !reset;
   assign csr_ready = 1'b1;

   hidb_hash #(.SEED(Seed0), .RANGE_BITS(7)) u_hash0 (
      .clock(clock), .advance(1'b1), .key_value(req_key_value),
      .range(nr), .picked(rank_w));
   hidb_hash #(.SEED(Seed1), .RANGE_BITS(7)) u_hash1 (
      .clock(clock), .advance(1'b1), .key_value(req_key_value),
      .range(nu), .picked(unit_w));

   assign rank_s = (rank_w >= 7'(MAX_RANKS)) ? RB'(MAX_RANKS - 1) : rank_w[RB-1:0];
   assign unit_s = (unit_w >= 7'(MAX_UNITS)) ? UB'(MAX_UNITS - 1) : unit_w[UB-1:0];

   assign fire = stage_ff[PIPE] && (!rsp_valid_ff || rsp_ready);
   assign mem_rd = stage_ff[3];
   assign rd_addr = {rank_s, unit_s};
   assign count = (rd_data == CMAX) ? rd_data : rd_data + 1'b1;
   assign launch = stage_ff[PIPE] && (32'(count) >= 32'(limit_ff));

   always_comb begin
      cstate_in = cstate_ff;
      clr_ptr_in = clr_ptr_ff;
      clr_end_in = clr_end_ff;
      nonempty_in = nonempty_ff;
      mem_wr = 1'b0;
      wr_addr = clr_ptr_ff[AB-1:0];
      wr_data = '0;
      flushed = '0;
      busy_in = busy_ff;
      if (req_valid && req_ready) busy_in = 1'b1;
      if (cstate_ff == CLR_SWEEP) begin
         mem_wr = 1'b1;
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_in == clr_end_ff) cstate_in = CLR_IDLE;
      end else if (fire) begin
         busy_in = 1'b0;
         nonempty_in[rank_hold_ff] = 1'b1;
         mem_wr = 1'b1;
         wr_addr = {rank_hold_ff, unit_hold_ff};
         wr_data = count;
         if (launch) begin
            nonempty_in[rank_hold_ff] = 1'b0;
            cstate_in = CLR_SWEEP;
            clr_ptr_in = {1'b0, rank_hold_ff, {UB{1'b0}}};
            clr_end_in = clr_ptr_in + (AB+1)'(SWEEP_RANK);
         end
         if (end_ff[PIPE]) begin
            for (int r = 0; r < MAX_RANKS && r < 32; r++) flushed[r] = nonempty_in[r];
            nonempty_in = '0;
            cstate_in = CLR_SWEEP;
            clr_ptr_in = '0;
            clr_end_in = (AB+1)'(SWEEP_ALL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff <= 6'd1;
         units_ff <= 7'd64;
         limit_ff <= 16'd1024;
         busy_ff <= 1'b0;
         stage_ff <= '0;
         nonempty_ff <= '0;
         cstate_ff <= CLR_SWEEP;
         clr_ptr_ff <= '0;
         clr_end_ff <= (AB+1)'(SWEEP_ALL);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RANK_COUNT: rank_count_ff <= csr_data[5:0];
               CSR_UNITS_PER_RANK: units_ff <= csr_data[6:0];
               CSR_BATCH_LIMIT: limit_ff <= csr_data;
               default: ;
            endcase
         end
         busy_ff <= busy_in;
         stage_ff <= {stage_ff[PIPE-1] || (stage_ff[PIPE] && !fire), stage_ff[PIPE-2:0],
                      req_valid && req_ready};
         nonempty_ff <= nonempty_in;
         cstate_ff <= cstate_in;
         clr_ptr_ff <= clr_ptr_in;
         clr_end_ff <= clr_end_in;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         end_ff[0] <= req_end_of_batch;
      end
      for (int i = 1; i < PIPE; i++) end_ff[i] <= end_ff[i-1];
      if (!stage_ff[PIPE] || fire) end_ff[PIPE] <= end_ff[PIPE-1];
      if (stage_ff[3]) begin
         rank_hold_ff <= rank_s;
         unit_hold_ff <= unit_s;
      end
      if (fire) begin
         rsp_rank_index <= 5'(rank_hold_ff);
         rsp_unit_index <= 6'(unit_hold_ff);
         rsp_slot_index <= 16'(count);
         rsp_rank_launch <= launch;
         rsp_flush_all <= end_ff[PIPE];
         rsp_flushed_ranks <= flushed;
      end
   end

   hidb_counter_mem #(.ADDR_BITS(AB), .COUNT_BITS(COUNT_BITS)) u_mem (
      .clock(clock), .rd_en(mem_rd), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(mem_wr), .wr_addr(wr_addr), .wr_data(wr_data));

   assign rsp_valid = rsp_valid_ff;
endmodule

[rtl/hidb_checker.sv]
// ============================================================================
// Dispatcher port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
`timescale 1ns / 1ps
`include "hashed_item_dispatch_batcher_macros.svh"
module hidb_checker
   import hidb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_rank_launch,
   input logic rsp_flush_all,
   input logic [31:0] rsp_flushed_ranks,
   input logic [15:0] rsp_slot_index
);
   `HIDB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `HIDB_ASSERT_NXT(a_launch_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_rank_launch))
   `HIDB_ASSERT_IMP(a_flush_zero, clock, reset, rsp_valid && !rsp_flush_all,
      rsp_flushed_ranks == 32'd0)
   `HIDB_ASSERT_IMP(a_slot_nonzero, clock, reset, rsp_valid, rsp_slot_index != 16'd0)
   `HIDB_ASSERT_NXT(a_no_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind hashed_item_dispatch_batcher hidb_checker u_hidb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rank_launch(rsp_rank_launch),
   .rsp_flush_all(rsp_flush_all), .rsp_flushed_ranks(rsp_flushed_ranks),
   .rsp_slot_index(rsp_slot_index));

[dv/testbench.sv]
// ============================================================================
// Key dispatcher testbench
// Drives keys and register writes into the dispatcher under random back pressure.
// Every response is checked against a built-in model of the hash, the per-unit fill
// counters, rank launches and end-of-batch flushes, or the values of typed table rows.
// ============================================================================
`timescale 1ns / 1ps
module testbench
   import hidb_pkg::*;
();

   localparam int NumRanks = 32;
   localparam int NumUnits = 64;
   localparam int CycleLimit = 1000000;
   localparam int RandomKeys = 1400;
   localparam logic [63:0] RankSeed = 64'hAAAAAAAA55555555 * 64'hB5B5B5B54B4B4B4B;
   localparam logic [63:0] UnitSeed = 64'h33333333CCCCCCCC * 64'hAA55AA5555335533;

   typedef struct packed {
      logic [4:0] rank;
      logic [5:0] unit;
      logic [15:0] slot;
      logic launch;
      logic flush;
      logic [31:0] flushed;
   } dispatch_type;

   typedef enum logic {ROW_KEY, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      csr_index_type index;
      logic [15:0] data;
      logic [63:0] key;
      logic eob;
      logic typed;
      logic [4:0] rank;
      logic launch;
      logic [31:0] flushed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [63:0] req_key_value = '0;
   logic req_end_of_batch = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [4:0] rsp_rank_index;
   logic [5:0] rsp_unit_index;
   logic [15:0] rsp_slot_index;
   logic rsp_rank_launch;
   logic rsp_flush_all;
   logic [31:0] rsp_flushed_ranks;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   logic [5:0] cfg_ranks;
   logic [6:0] cfg_units;
   logic [15:0] cfg_limit;
   logic [15:0] fill_count [NumRanks*NumUnits];
   logic [NumRanks-1:0] rank_busy;

   dispatch_type expected_dispatch [$];
   stim_row_type override_rows [$];
   int errors = 0;
   int cycles = 0;
   bit hold_rsp = 1'b0;
   bit rsp_held = 1'b0;

   hashed_item_dispatch_batcher dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [63:0] key_hash(input logic [63:0] key, input logic [63:0] seed);
      logic [63:0] h;
      h = seed;
      h = h ^ ((h << 7) ^ (key * (h >> 3)) ^ (~((h << 11) + (key ^ (h >> 5)))));
      h = (~h) + (h << 21);
      h = h ^ (h >> 24);
      h = h * 64'd265;
      h = h ^ (h >> 14);
      h = h * 64'd21;
      h = h ^ (h >> 28);
      h = h + (h << 31);
      return h;
   endfunction

   function automatic logic [31:0] scale_range(input logic [63:0] word, input logic [31:0] span);
      logic [63:0] p;
      p = {32'd0, word[31:0]} * {32'd0, span};
      return p[63:32];
   endfunction

   function automatic dispatch_type dispatch_key(input logic [63:0] key, input logic eob);
      dispatch_type d;
      logic [31:0] nr, nu, r, u;
      logic [10:0] idx;
      nr = (cfg_ranks > 6'(NumRanks)) ? 32'(NumRanks) : 32'(cfg_ranks);
      nu = (cfg_units > 7'(NumUnits)) ? 32'(NumUnits) : 32'(cfg_units);
      r = scale_range(key_hash(key, RankSeed), nr);
      u = scale_range(key_hash(key, UnitSeed), nu);
      idx = {r[4:0], u[5:0]};
      if (fill_count[idx] != 16'hFFFF) fill_count[idx]++;
      d.rank = r[4:0];
      d.unit = u[5:0];
      d.slot = fill_count[idx];
      d.launch = (d.slot >= cfg_limit);
      d.flush = eob;
      d.flushed = '0;
      rank_busy[r[4:0]] = 1'b1;
      if (d.launch) begin
         for (int i = 0; i < NumUnits; i++) fill_count[{r[4:0], 6'(i)}] = '0;
         rank_busy[r[4:0]] = 1'b0;
      end
      if (eob) begin
         d.flushed = rank_busy;
         foreach (fill_count[i]) fill_count[i] = '0;
         rank_busy = '0;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      dispatch_type d, got;
      stim_row_type row;
      if (reset) begin
         cfg_ranks <= 6'd1;
         cfg_units <= 7'd64;
         cfg_limit <= 16'd1024;
         foreach (fill_count[i]) fill_count[i] = '0;
         rank_busy = '0;
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RANK_COUNT: cfg_ranks <= csr_data[5:0];
            CSR_UNITS_PER_RANK: cfg_units <= csr_data[6:0];
            CSR_BATCH_LIMIT: cfg_limit <= csr_data;
            default: ;
         endcase
      end
      if (!reset && req_valid && req_ready) begin
         d = dispatch_key(req_key_value, req_end_of_batch);
         if (override_rows.size() > 0) begin
            row = override_rows.pop_front();
            if (row.typed) begin
               d.rank = row.rank;
               d.launch = row.launch;
               d.flush = row.eob;
               d.flushed = row.flushed;
            end
         end
         expected_dispatch.insert(expected_dispatch.size(), d);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_rank_index, rsp_unit_index, rsp_slot_index, rsp_rank_launch,
                 rsp_flush_all, rsp_flushed_ranks};
         if (expected_dispatch.size() == 0) begin
            $error("response transfer with nothing expected");
            errors++;
         end else begin
            d = expected_dispatch.pop_front();
            if (got.rank != d.rank) begin
               $error("rank_index expected %0d got %0d", d.rank, got.rank); errors++;
            end
            if (got.unit != d.unit) begin
               $error("unit_index expected %0d got %0d", d.unit, got.unit); errors++;
            end
            if (got.slot != d.slot) begin
               $error("slot_index expected %0d got %0d", d.slot, got.slot); errors++;
            end
            if (got.launch != d.launch) begin
               $error("rank_launch expected %0d got %0d", d.launch, got.launch); errors++;
            end
            if (got.flush != d.flush) begin
               $error("flush_all expected %0d got %0d", d.flush, got.flush); errors++;
            end
            if (got.flushed != d.flushed) begin
               $error("flushed_ranks expected %h got %h", d.flushed, got.flushed); errors++;
            end
         end
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp && !rsp_held) begin
            rsp_held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         repeat (n) @(posedge clock);
      end
   end

   task automatic wait_drained();
      while (expected_dispatch.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Called at a rising edge; returns at the transfer edge (valid high) or after a gap.
   task automatic send_key(input logic [63:0] key, input logic eob, input bit gaps);
      int g;
      req_valid <= 1'b1;
      req_key_value <= key;
      req_end_of_batch <= eob;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      if (gaps && $urandom_range(0, 2) == 0) begin
         g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic run_row(input stim_row_type row);
      if (row.kind == ROW_CSR) begin
         req_valid <= 1'b0;
         @(posedge clock);
         write_csr(row.index, row.data);
      end else begin
         override_rows.insert(override_rows.size(), row);
         send_key(row.key, row.eob, 1'b1);
      end
   endtask

   function automatic stim_row_type csr_row(input csr_index_type idx, input logic [15:0] v);
      return '{ROW_CSR, idx, v, '0, 1'b0, 1'b0, '0, 1'b0, '0};
   endfunction

   function automatic stim_row_type key_row(input logic [63:0] k, input logic eob);
      return '{ROW_KEY, CSR_RANK_COUNT, '0, k, eob, 1'b0, '0, 1'b0, '0};
   endfunction

   function automatic stim_row_type typed_row(input logic [63:0] k, input logic eob,
                                              input logic launch, input logic [31:0] fl);
      return '{ROW_KEY, CSR_RANK_COUNT, '0, k, eob, 1'b1, 5'd0, launch, fl};
   endfunction

   initial begin
      stim_row_type table_rows [$];
      logic [63:0] pool [8];
      logic [63:0] k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      table_rows = '{
         typed_row(64'd0, 1'b0, 1'b0, 32'd0),
         typed_row(64'd0, 1'b0, 1'b0, 32'd0),
         typed_row(64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0, 32'd1),
         csr_row(CSR_BATCH_LIMIT, 16'd1),
         typed_row(64'h8000000000000000, 1'b0, 1'b1, 32'd0),
         typed_row(64'h5555AAAA5555AAAA, 1'b1, 1'b1, 32'd0),
         csr_row(CSR_BATCH_LIMIT, 16'd0),
         typed_row(64'd1, 1'b0, 1'b1, 32'd0),
         csr_row(CSR_RANK_COUNT, 16'd0),
         csr_row(CSR_BATCH_LIMIT, 16'hFFFF),
         typed_row(64'h123456789ABCDEF0, 1'b0, 1'b0, 32'd0),
         csr_row(CSR_RANK_COUNT, 16'd63),
         csr_row(CSR_UNITS_PER_RANK, 16'd0),
         key_row(64'hDEADBEEFCAFEF00D, 1'b0),
         csr_row(CSR_UNITS_PER_RANK, 16'd127),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b0),
         key_row(64'hF0F0F0F0F0F0F0F0, 1'b0),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b0),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b1),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b0),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b0),
         csr_row(CSR_BATCH_LIMIT, 16'd2),
         key_row(64'h0F0F0F0F0F0F0F0F, 1'b0),
         csr_row(CSR_UNITS_PER_RANK, 16'd1),
         key_row(64'h7, 1'b1)
      };
      foreach (table_rows[i]) run_row(table_rows[i]);

      for (int phase = 0; phase < 7; phase++) begin
         req_valid <= 1'b0;
         @(posedge clock);
         case (phase)
            0: begin write_csr(CSR_RANK_COUNT, 16'd32); write_csr(CSR_UNITS_PER_RANK, 16'd64);
               write_csr(CSR_BATCH_LIMIT, 16'd8); end
            1: begin write_csr(CSR_RANK_COUNT, 16'd1); write_csr(CSR_UNITS_PER_RANK, 16'd1);
               write_csr(CSR_BATCH_LIMIT, 16'hFFFF); end
            2: begin write_csr(CSR_RANK_COUNT, 16'd4); write_csr(CSR_UNITS_PER_RANK, 16'd3);
               write_csr(CSR_BATCH_LIMIT, 16'd5); end
            3: begin write_csr(CSR_RANK_COUNT, 16'd63); write_csr(CSR_UNITS_PER_RANK, 16'd127);
               write_csr(CSR_BATCH_LIMIT, 16'd1024); end
            4: begin write_csr(CSR_RANK_COUNT, 16'($urandom_range(1, 32)));
               write_csr(CSR_UNITS_PER_RANK, 16'($urandom_range(1, 64)));
               write_csr(CSR_BATCH_LIMIT, 16'($urandom_range(0, 12))); end
            5: begin write_csr(CSR_RANK_COUNT, 16'd0); write_csr(CSR_UNITS_PER_RANK, 16'd2);
               write_csr(CSR_BATCH_LIMIT, 16'd3); end
            default: begin write_csr(CSR_RANK_COUNT, 16'd17);
               write_csr(CSR_UNITS_PER_RANK, 16'd64); write_csr(CSR_BATCH_LIMIT, 16'd2); end
         endcase
         foreach (pool[i]) pool[i] = {$urandom, $urandom};
         if (phase == 1) hold_rsp = 1'b1;
         for (int n = 0; n < RandomKeys / 7; n++) begin
            if (n == 100) begin
               req_valid <= 1'b0;
               @(posedge clock);
               wait_drained();
            end
            k = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)] : {$urandom, $urandom};
            send_key(k, ($urandom_range(0, 49) == 0), 1'b1);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/hidb_pkg.sv
rtl/hidb_hash.sv
rtl/hidb_counter_mem.sv
rtl/hashed_item_dispatch_batcher.sv
rtl/hidb_checker.sv
dv/testbench.sv
